// ===== design/hrbp_pkg.sv =====
// shared types, constants and per-byte step functions for the request byte parser
package hrbp_pkg;

  localparam int LENGTH_BITS = 31;
  localparam int LW = LENGTH_BITS;

  // request phase, also reported as status
  typedef enum logic [2:0] {
    PH_REQ  = 3'd0,
    PH_HDR  = 3'd1,
    PH_BODY = 3'd2,
    PH_DONE = 3'd3,
    PH_ERR  = 3'd4
  } phase_t;

  // content-length number scanner
  typedef enum logic [2:0] {
    NP_WS     = 3'd0,
    NP_PLUS   = 3'd1,
    NP_MINUS  = 3'd2,
    NP_DIGITS = 3'd3,
    NP_ZERO   = 3'd4,
    NP_END    = 3'd5,
    NP_BAD    = 3'd6
  } num_phase_t;

  // field within a line
  typedef enum logic [1:0] {
    FI_FIRST  = 2'd0,
    FI_SECOND = 2'd1,
    FI_THIRD  = 2'd2
  } field_t;

  localparam logic [3:0] ROLE_METHOD  = 4'd0;
  localparam logic [3:0] ROLE_PATH    = 4'd1;
  localparam logic [3:0] ROLE_QUERY   = 4'd2;
  localparam logic [3:0] ROLE_VERSION = 4'd3;
  localparam logic [3:0] ROLE_HNAME   = 4'd4;
  localparam logic [3:0] ROLE_HVALUE  = 4'd5;
  localparam logic [3:0] ROLE_BODY    = 4'd6;
  localparam logic [3:0] ROLE_EOL     = 4'd7;
  localparam logic [3:0] ROLE_SEP     = 4'd8;
  localparam logic [3:0] ROLE_IGNORED = 4'd9;

  localparam logic [2:0] MC_UNKNOWN = 3'd5;
  localparam logic [1:0] VC_UNKNOWN = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [3:0] CLEN_LEN = 4'd14;
  localparam logic [3:0] VER_LEN  = 4'd8;

  localparam logic [7:0] METH_TXT [5][8] = '{
    '{"G", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"P", "O", "S", "T", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"H", "E", "A", "D", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"P", "U", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"D", "E", "L", "E", "T", "E", 8'h0, 8'h0}
  };
  localparam logic [3:0] METH_LEN [5] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd6};
  localparam logic [7:0] VER_TXT [2][8] = '{
    '{"H", "T", "T", "P", "/", "1", ".", "0"},
    '{"H", "T", "T", "P", "/", "1", ".", "1"}
  };
  localparam logic [7:0] CLEN_TXT [16] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", 8'h0, 8'h0
  };

  localparam logic [LW+3:0] LEN_MAX = {4'b0, {LW{1'b1}}};

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  role;
    logic        line_done;
    logic [2:0]  method_code;
    logic [1:0]  version_code;
    logic [30:0] content_length;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic       cr_pending;
    logic       line_empty;
    field_t     field;
    logic       in_query;
    logic [3:0] pos;
    logic [4:0] cand;
    logic       name_is_len;
    num_phase_t nphase;
    logic [LW-1:0] acc;
    logic [LW-1:0] blen;
    logic [LW-1:0] brem;
    logic [2:0] saved_method;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic [3:0] role;
  } ld_t;

  typedef struct packed {
    st_t        st;
    logic [2:0] mc;
    logic [1:0] vc;
  } le_t;

  // results of one accepted beat, towards the result queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic st_t new_line(st_t s);
    st_t r;
    r = s;
    r.line_empty  = 1'b1;
    r.field       = FI_FIRST;
    r.in_query    = 1'b0;
    r.pos         = 4'd0;
    r.cand        = 5'h1f;
    r.name_is_len = 1'b1;
    r.nphase      = NP_WS;
    r.acc         = '0;
    return r;
  endfunction

  function automatic st_t reset_st();
    st_t r;
    r              = '0;
    r.phase        = PH_REQ;
    r.cr_pending   = 1'b0;
    r.saved_method = 3'd0;
    r.blen         = '0;
    r.brem         = '0;
    return new_line(r);
  endfunction

  function automatic logic [3:0] bump(logic [3:0] p);
    return (p < 4'd15) ? p + 4'd1 : p;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // stoi-like decimal scan of the content-length value
  function automatic st_t number_feed(st_t s, logic [7:0] c);
    st_t r;
    logic dig;
    logic [7:0] dd;
    logic [3:0] d;
    logic [LW+3:0] v;
    r   = s;
    dig = (c >= 8'h30) && (c <= 8'h39);
    dd  = c - CH_ZERO;
    d   = dd[3:0];
    v   = (LW+4)'(s.acc) * (LW+4)'(10) + (LW+4)'(d);
    case (s.nphase)
      NP_WS: begin
        if (!is_ws(c)) begin
          if (c == CH_PLUS) r.nphase = NP_PLUS;
          else if (c == CH_MINUS) r.nphase = NP_MINUS;
          else if (dig) begin
            r.acc    = LW'(d);
            r.nphase = NP_DIGITS;
          end else r.nphase = NP_BAD;
        end
      end
      NP_PLUS: begin
        if (dig) begin
          r.acc    = LW'(d);
          r.nphase = NP_DIGITS;
        end else r.nphase = NP_BAD;
      end
      NP_MINUS, NP_ZERO: begin
        if (dig) r.nphase = (d != 4'd0) ? NP_BAD : NP_ZERO;
        else r.nphase = (s.nphase == NP_ZERO) ? NP_END : NP_BAD;
        if (r.nphase != NP_BAD) r.acc = '0;
      end
      NP_DIGITS: begin
        if (dig) begin
          if (v > LEN_MAX) r.nphase = NP_BAD;
          else r.acc = v[LW-1:0];
        end else r.nphase = NP_END;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one byte of line data: role and state update
  function automatic ld_t line_data(st_t s, logic [7:0] b);
    ld_t r;
    logic [7:0] lc;
    logic [2:0] m;
    r.st            = s;
    r.role          = ROLE_IGNORED;
    r.st.line_empty = 1'b0;
    lc = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    m  = MC_UNKNOWN;
    if (s.phase == PH_REQ) begin
      if (s.field == FI_FIRST) begin
        if (b == CH_SP) begin
          for (int i = 4; i >= 0; i--)
            if (s.cand[i] && METH_LEN[i] == s.pos) m = 3'(i);
          r.st.saved_method = m;
          r.st.field        = FI_SECOND;
          r.st.in_query     = 1'b0;
          r.role            = ROLE_SEP;
        end else begin
          for (int i = 0; i < 5; i++)
            if (s.pos >= METH_LEN[i] || METH_TXT[i][s.pos[2:0]] != b) r.st.cand[i] = 1'b0;
          r.st.pos = bump(s.pos);
          r.role   = ROLE_METHOD;
        end
      end else if (s.field == FI_SECOND) begin
        if (b == CH_SP) begin
          r.st.field = FI_THIRD;
          r.st.pos   = 4'd0;
          r.st.cand  = 5'h03;
          r.role     = ROLE_SEP;
        end else if (!s.in_query && b == CH_QMARK) begin
          r.st.in_query = 1'b1;
          r.role        = ROLE_SEP;
        end else begin
          r.role = s.in_query ? ROLE_QUERY : ROLE_PATH;
        end
      end else begin
        for (int i = 0; i < 2; i++)
          if (s.pos >= VER_LEN || VER_TXT[i][s.pos[2:0]] != b) r.st.cand[i] = 1'b0;
        r.st.pos = bump(s.pos);
        r.role   = ROLE_VERSION;
      end
    end else begin
      if (s.field == FI_FIRST) begin
        if (b == CH_COLON) begin
          if (s.pos != CLEN_LEN) r.st.name_is_len = 1'b0;
          r.st.field = FI_SECOND;
          r.role     = ROLE_SEP;
        end else begin
          if (s.pos >= CLEN_LEN || CLEN_TXT[s.pos] != lc) r.st.name_is_len = 1'b0;
          r.st.pos = bump(s.pos);
          r.role   = ROLE_HNAME;
        end
      end else if (s.field == FI_SECOND) begin
        r.st.field = FI_THIRD;
        r.role     = ROLE_IGNORED;
      end else begin
        r.st   = number_feed(r.st, b);
        r.role = ROLE_HVALUE;
      end
    end
    return r;
  endfunction

  // close of a request or header line
  function automatic le_t line_end(st_t s);
    le_t r;
    r.st = s;
    r.mc = 3'd0;
    r.vc = 2'd0;
    if (s.phase == PH_REQ) begin
      if (s.field != FI_THIRD) begin
        r.st.phase = PH_ERR;
        r.mc       = MC_UNKNOWN;
        r.vc       = VC_UNKNOWN;
      end else begin
        r.mc = s.saved_method;
        r.vc = VC_UNKNOWN;
        for (int i = 1; i >= 0; i--)
          if (s.cand[i] && s.pos == VER_LEN) r.vc = 2'(i);
        r.st.phase = PH_HDR;
      end
    end else if (s.line_empty) begin
      r.st.brem  = s.blen;
      r.st.phase = (s.blen != '0) ? PH_BODY : PH_DONE;
    end else if (s.field == FI_FIRST) begin
      r.st.phase = PH_ERR;
    end else if (s.name_is_len) begin
      if (s.nphase == NP_DIGITS || s.nphase == NP_ZERO || s.nphase == NP_END)
        r.st.blen = s.acc;
      else
        r.st.phase = PH_ERR;
    end
    r.st = new_line(r.st);
    return r;
  endfunction

  function automatic res_t mk(st_t s, logic [7:0] b, logic [3:0] role, logic done,
                              logic [2:0] mc, logic [1:0] vc);
    res_t r;
    r.out_byte       = b;
    r.role           = role;
    r.line_done      = done;
    r.method_code    = mc;
    r.version_code   = vc;
    r.content_length = 31'(s.blen);
    r.status         = s.phase;
    r.last           = 1'b0;
    return r;
  endfunction

  typedef struct packed {
    st_t   st;
    push_t p;
  } step_t;

  // full per-beat update
  function automatic step_t step(st_t s, in_t x);
    step_t o;
    ld_t ld;
    ld_t ld2;
    le_t le;
    logic [7:0] b;
    b      = x.data_byte;
    o.st   = s;
    o.p.n  = 2'd0;
    o.p.r0 = '0;
    o.p.r1 = '0;
    if (x.mode) begin
      o.st = reset_st();
    end else if (s.phase == PH_REQ || s.phase == PH_HDR) begin
      if (s.cr_pending) begin
        o.st.cr_pending = 1'b0;
        if (b == CH_LF) begin
          o.p.r0 = mk(o.st, CH_CR, ROLE_EOL, 1'b0, 3'd0, 2'd0);
          le     = line_end(o.st);
          o.st   = le.st;
          o.p.r1 = mk(o.st, b, ROLE_EOL, 1'b1, le.mc, le.vc);
          o.p.n  = 2'd2;
        end else begin
          ld     = line_data(o.st, CH_CR);
          o.st   = ld.st;
          o.p.r0 = mk(o.st, CH_CR, ld.role, 1'b0, 3'd0, 2'd0);
          o.p.n  = 2'd1;
          if (b == CH_CR) begin
            o.st.cr_pending = 1'b1;
          end else begin
            ld2    = line_data(o.st, b);
            o.st   = ld2.st;
            o.p.r1 = mk(o.st, b, ld2.role, 1'b0, 3'd0, 2'd0);
            o.p.n  = 2'd2;
          end
        end
      end else if (b == CH_CR) begin
        o.st.cr_pending = 1'b1;
      end else begin
        ld     = line_data(o.st, b);
        o.st   = ld.st;
        o.p.r0 = mk(o.st, b, ld.role, 1'b0, 3'd0, 2'd0);
        o.p.n  = 2'd1;
      end
    end else if (s.phase == PH_BODY) begin
      if (s.brem != '0) o.st.brem = s.brem - LW'(1);
      if (o.st.brem == '0) o.st.phase = PH_DONE;
      o.p.r0 = mk(o.st, b, ROLE_BODY, 1'b0, 3'd0, 2'd0);
      o.p.n  = 2'd1;
    end else begin
      o.p.r0 = mk(o.st, b, ROLE_IGNORED, 1'b0, 3'd0, 2'd0);
      o.p.n  = 2'd1;
    end
    if (o.p.n == 2'd1) o.p.r0.last = 1'b1;
    if (o.p.n == 2'd2) o.p.r1.last = 1'b1;
    return o;
  endfunction

endpackage

// ===== design/hrbp_core.sv =====
// input register, parser state and per-beat classification
module hrbp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  hrbp_pkg::in_t  in_data,
  output logic           in_stall,
  input  logic           room,
  output hrbp_pkg::push_t push
);

  logic             in_valid_r, in_valid_nxt;
  hrbp_pkg::in_t    in_data_r;
  hrbp_pkg::st_t    st_r, st_nxt;
  hrbp_pkg::step_t  stp;
  logic             advance, accept;

  // handshake on the input register
  assign advance  = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign accept   = in_valid && !in_stall;
  assign in_valid_nxt = accept || (in_valid_r && !advance);

  // single pass over the held beat
  always_comb begin
    stp    = hrbp_pkg::step(st_r, in_data_r);
    st_nxt = advance ? stp.st : st_r;
    push   = stp.p;
    if (!advance) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= hrbp_pkg::reset_st();
    end else begin
      in_valid_r <= in_valid_nxt;
      st_r       <= st_nxt;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (accept) in_data_r <= in_data;
  end

endmodule

// ===== design/hrbp_rq.sv =====
// four-entry result queue, takes up to two results a cycle and gives one, none while out_stall is high
module hrbp_rq (
  input  logic            clk,
  input  logic            rst_n,
  input  hrbp_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  output hrbp_pkg::res_t  out_data,
  input  logic            out_stall
);

  hrbp_pkg::res_t mem [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt, cnt_left;
  logic       pop;

  // occupancy and space for a two-result beat
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && !out_stall;
  assign cnt_left  = cnt_r - {2'b0, pop};
  assign room      = cnt_left <= 3'd2;
  assign cnt_nxt   = cnt_left + {1'b0, push.n};
  assign wr_nxt    = wr_r + push.n;
  assign rd_nxt    = rd_r + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_r] <= push.r0;
    if (push.n == 2'd2) mem[wr_r + 2'd1] <= push.r1;
  end

endmodule

// ===== design/http_request_byte_parser.sv =====
// HTTP request byte parser: one request byte per beat in, one tagged result per beat out.
// A beat is taken every cycle while the queue has room for two results; a byte that yields two
// results (a held CR resolved with the next byte) pushes both at once. The input rate is one byte
// per cycle, set by the combinational step logic, limited by the one-result-per-cycle output of
// the four-entry result queue. Each beat passes the input register, then the result queue. While
// parsing lines, a CR yields no result until the next byte; a restart beat (mode 1) yields none.
module http_request_byte_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  hrbp_pkg::in_t  in_data,
  output logic           in_stall,
  output logic           out_valid,
  output hrbp_pkg::res_t out_data,
  input  logic           out_stall
);

  hrbp_pkg::push_t push;
  logic            room;

  // classification
  hrbp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .room     (room),
    .push     (push)
  );

  // result queue
  hrbp_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== design/hrbp_checker.sv =====
// port-level checks for the request byte parser
module hrbp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input hrbp_pkg::res_t out_data,
  input logic           out_stall
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // second result of a byte is already queued
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("second result missing");

  // line close is a line end beat
  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_done |-> out_data.role == hrbp_pkg::ROLE_EOL
      && out_data.last)
    else $error("line close on wrong role");

  // codes only on line close
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.line_done |->
      out_data.method_code == 3'd0 && out_data.version_code == 2'd0)
    else $error("codes outside line close");

  // status in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= 3'd4)
    else $error("status out of range");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);
